// ===== rtl/cdn_pkg.sv =====
// cdn_pkg: constants and calendar tables for the day number converter
// no dependencies; imported by calendar_day_number_converter

package cdn_pkg;

  localparam int unsigned FIRST_YEAR     = 1901;
  localparam int unsigned LAST_YEAR      = 2099;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned DAYS_PER_CYCLE = 1461;
  localparam int unsigned LEAP_EVERY     = 4;
  localparam int unsigned NUM_CYCLES     = 50;

  localparam logic signed [16:0] FIRST_DAYNUM = -17'sd25202;
  localparam logic signed [16:0] LAST_DAYNUM  = 17'sd47481;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic CMD_DATE_TO_NUM = 1'b0;
  localparam logic CMD_NUM_TO_DATE = 1'b1;

  // length of a month in a common year
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    unique case (month)
      4'd2:                   len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  // days in a common year before the first of the month
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // first day of a four-year cycle, counted from 1901-01-01
  function automatic logic [16:0] cycle_start(input int unsigned cycle);
    return 17'(cycle * DAYS_PER_CYCLE);
  endfunction

endpackage

// ===== rtl/calendar_day_number_converter.sv =====
// calendar_day_number_converter: date <-> day number since 1970-01-01
// depends on cdn_pkg (tables and constants)
//
//  channel  dir  tdata (low bit up)                                     tuser
//  s_axis   in   in_year[11:0] in_month[15:12] in_day[20:16]            cmd
//                in_day_number[37:21] zero[39:38]
//  m_axis   out  out_day_number[16:0] out_year[28:17] out_month[32:29]  range_error
//                out_day[37:33] zero[39:38]
//
// one beat per cycle sustained while m_axis_tready stays high
// input to output passes an input register, the conversion logic and an output register
// the stages advance together whenever the output register is empty or taken
// a stall on m_axis holds both stages and drops s_axis_tready once both are full
// rst clears the valid flags only

module calendar_day_number_converter
  import cdn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // in_year, in_month, in_day, in_day_number, pad
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_day_number, out_year, out_month, out_day, pad
  output logic        m_axis_tuser    // range_error
);

  // input register
  logic               in_valid;
  logic               cmd;
  logic [11:0]        in_year;
  logic [3:0]         in_month;
  logic [4:0]         in_day;
  logic signed [16:0] in_day_number;

  // result register
  logic               out_valid;
  logic [16:0]        out_day_number;
  logic [11:0]        out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day;
  logic               range_error;

  logic               advance;

  // date to day number
  logic               leap;
  logic [4:0]         mlen;
  logic               date_ok;
  logic [7:0]         yoff;
  logic [16:0]        date_days;

  // day number to date
  logic               dn_ok;
  logic [16:0]        n;
  logic [5:0]         q;
  logic [16:0]        base;
  logic [10:0]        r;
  logic [1:0]         yr;
  logic [10:0]        yr_days;
  logic [8:0]         ry;
  logic               leap_nd;
  logic [3:0]         m;
  logic [8:0]         mbase;
  logic [8:0]         mstart;

  logic [16:0]        out_day_number_next;
  logic [11:0]        out_year_next;
  logic [3:0]         out_month_next;
  logic [4:0]         out_day_next;
  logic               range_error_next;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_comb begin
    leap    = (in_year[1:0] == 2'b00);
    mlen    = month_len(in_month) + 5'((in_month == MONTH_FEB) && leap);
    date_ok = (in_year >= 12'(FIRST_YEAR)) && (in_year <= 12'(LAST_YEAR))
           && (in_month >= MONTH_JAN) && (in_month <= MONTH_DEC)
           && (in_day != 5'd0) && (in_day <= mlen);
    yoff      = 8'(in_year - 12'(FIRST_YEAR));
    date_days = 17'(17'(yoff) * 17'(DAYS_PER_YEAR))
              + 17'(yoff >> 2)
              + 17'(days_before(in_month))
              + 17'(leap && (in_month > MONTH_FEB))
              + 17'(in_day) - 17'd1;
  end

  always_comb begin
    dn_ok = (in_day_number >= FIRST_DAYNUM) && (in_day_number <= LAST_DAYNUM);
    n     = 17'(in_day_number - FIRST_DAYNUM);
    q     = 6'd0;
    base  = 17'd0;
    for (int unsigned i = 1; i < NUM_CYCLES; i++) begin
      if (n >= cycle_start(i)) begin
        q    = 6'(i);
        base = cycle_start(i);
      end
    end
    r = 11'(n - base);
    if (r >= 11'(3 * DAYS_PER_YEAR)) begin
      yr      = 2'd3;
      yr_days = 11'(3 * DAYS_PER_YEAR);
    end else if (r >= 11'(2 * DAYS_PER_YEAR)) begin
      yr      = 2'd2;
      yr_days = 11'(2 * DAYS_PER_YEAR);
    end else if (r >= 11'(DAYS_PER_YEAR)) begin
      yr      = 2'd1;
      yr_days = 11'(DAYS_PER_YEAR);
    end else begin
      yr      = 2'd0;
      yr_days = 11'd0;
    end
    ry      = 9'(r - yr_days);
    leap_nd = (yr == 2'd3);
    m       = MONTH_JAN;
    mbase   = 9'd0;
    for (int unsigned i = 2; i <= 12; i++) begin
      mstart = days_before(4'(i)) + 9'(leap_nd && (i > 2));
      if (ry >= mstart) begin
        m     = 4'(i);
        mbase = mstart;
      end
    end
  end

  always_comb begin
    out_day_number_next = 17'd0;
    out_year_next       = 12'd0;
    out_month_next      = 4'd0;
    out_day_next        = 5'd0;
    range_error_next    = 1'b0;
    if (cmd == CMD_DATE_TO_NUM) begin
      if (date_ok) begin
        out_day_number_next = 17'(date_days + 17'(FIRST_DAYNUM));
      end else begin
        range_error_next = 1'b1;
      end
    end else begin
      if (dn_ok) begin
        out_year_next  = 12'(FIRST_YEAR) + 12'({q, 2'b00}) + 12'(yr);
        out_month_next = m;
        out_day_next   = 5'(ry - mbase + 9'd1);
      end else begin
        range_error_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      cmd           <= s_axis_tuser;
      in_year       <= s_axis_tdata[11:0];
      in_month      <= s_axis_tdata[15:12];
      in_day        <= s_axis_tdata[20:16];
      in_day_number <= $signed(s_axis_tdata[37:21]);
    end
    if (advance && in_valid) begin
      out_day_number <= out_day_number_next;
      out_year       <= out_year_next;
      out_month      <= out_month_next;
      out_day        <= out_day_next;
      range_error    <= range_error_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_day, out_month, out_year, out_day_number};
  assign m_axis_tuser  = range_error;

`ifndef NO_ASSERTIONS
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |->
      out_day_number == 17'd0 && out_year == 12'd0 && out_month == 4'd0 && out_day == 5'd0)
    else $error("error result with nonzero fields");

  a_date_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_error && out_month != 4'd0 |->
      out_month <= MONTH_DEC && out_day != 5'd0 && out_year >= 12'(FIRST_YEAR)
      && out_day_number == 17'd0)
    else $error("decoded date out of range");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> in_valid)
    else $error("accepted beat not held in input register");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_day_number) && $stable(cmd))
    else $error("input register changed while stalled");
`endif

endmodule
